[hdl/short_key_hash_table_macros.svh]
// Assertion macros for the short key hash table checker.
// No dependencies; included by the checker file.
`ifndef SHORT_KEY_HASH_TABLE_MACROS_SVH
`define SHORT_KEY_HASH_TABLE_MACROS_SVH

// checked only outside reset
`define SKHT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define SKHT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/skht_pkg.sv]
// Shared types, constants and codes of the short key hash table.
// No dependencies.
`timescale 1ns / 1ps
package skht_pkg;
  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int LIM_W = $clog2((TABLE_SLOTS + 1) * 100 + 1);
  localparam int FIFO_DEPTH = 4;

  localparam logic [63:0] GOLDEN_MUL = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] FINAL_MUL = 64'hBF58476D1CE4E5B9;
  localparam logic [6:0] LIMIT_CAP = 7'd99;
  localparam logic [6:0] LIMIT_RESET = 7'd70;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_UPSERT = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] tag;
    logic [63:0] key;
    logic [31:0] value;
    logic [SLOT_W-1:0] home;
  } item_t;

  typedef struct packed {
    logic [3:0] tag;
    logic [63:0] key;
    logic [31:0] value;
  } slot_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;
endpackage

[hdl/skht_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module skht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/skht_front.sv]
// Front end: accepts requests, packs the key and hashes it to a home slot.
// Depends on skht_pkg.
`timescale 1ns / 1ps
module skht_front import skht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] key_bytes,
  input  logic [3:0]  key_len,
  input  logic [31:0] new_value,
  input  q_status_t   q_status,
  output logic        push,
  output item_t       push_item
);
  logic adv;
  logic v0, v1, v2, v3, v4;
  item_t it0, it1, it2, it3, it4;
  logic [63:0] h0, ll1, h2, ll3;
  logic [31:0] x1, x3;
  logic [3:0] len_c;
  logic [63:0] packed_key;
  logic [63:0] p2, t2, q4, r4;
  logic [31:0] hs4;
  item_t in_item;
  item_t it3_home;

  function automatic logic [63:0] pack(input logic [63:0] w, input logic [3:0] len);
    logic [63:0] k;
    logic [5:0] pos;
    k = '0;
    pos = '0;
    if (len[3]) begin
      k = w;
    end else begin
      if (len[2]) begin
        k = {32'b0, w[31:0]};
        pos = 6'd32;
      end
      if (len[1]) begin
        k = {k[47:0], 16'b0} | {48'b0, w[pos +: 16]};
        pos = pos + 6'd16;
      end
      if (len[0]) begin
        k = {k[55:0], 8'b0} | {56'b0, w[pos +: 8]};
      end
    end
    return k;
  endfunction

  assign adv = !(v4 && q_status.full);
  assign in_stall = !adv;
  assign push = v4 && !q_status.full;
  assign push_item = it4;

  always_comb begin
    len_c = (key_len > 4'd8) ? 4'd8 : key_len;
    packed_key = pack(key_bytes, len_c);
    in_item.mode = mode;
    in_item.tag = len_c + 4'd1;
    in_item.key = packed_key;
    in_item.value = new_value;
    in_item.home = '0;
    p2 = ll1 + {x1, 32'b0};
    t2 = p2 ^ (p2 >> 29);
    q4 = ll3 + {x3, 32'b0};
    r4 = q4 ^ (q4 >> 29);
    hs4 = r4[31:0] ^ r4[63:32];
    it3_home = it3;
    it3_home.home = SLOT_W'(hs4 % TABLE_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (adv) begin
      it0 <= in_item;
      h0 <= GOLDEN_MUL ^ {60'b0, len_c} ^ packed_key;
      it1 <= it0;
      ll1 <= h0[31:0] * GOLDEN_MUL[31:0];
      x1 <= 32'(h0[63:32] * GOLDEN_MUL[31:0]) + 32'(h0[31:0] * GOLDEN_MUL[63:32]);
      it2 <= it1;
      h2 <= t2 ^ (t2 >> 32);
      it3 <= it2;
      ll3 <= h2[31:0] * FINAL_MUL[31:0];
      x3 <= 32'(h2[63:32] * FINAL_MUL[31:0]) + 32'(h2[31:0] * FINAL_MUL[63:32]);
      it4 <= it3_home;
    end
  end
endmodule

[hdl/skht_fifo.sv]
// Short request queue between front end and probe engine.
// Depends on skht_pkg.
`timescale 1ns / 1ps
module skht_fifo import skht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     head,
  output q_status_t q_status
);
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_QW = $clog2(FIFO_DEPTH + 1);

  item_t mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_QW-1:0] count;

  assign head = mem[rptr];
  assign q_status.empty = (count == '0);
  assign q_status.full = (count == CNT_QW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_QW'(push) - CNT_QW'(pop);
    end
    if (push) begin
      mem[wptr] <= push_item;
    end
  end
endmodule

[hdl/skht_back.sv]
// Probe engine: clears, looks up and upserts slots in the slot RAM.
// Depends on skht_pkg and skht_ram.
`timescale 1ns / 1ps
module skht_back import skht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data,
  input  q_status_t   q_status,
  input  item_t       head,
  output logic        pop,
  output logic        init_busy,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] found_value
);
  typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_READ, ST_CHECK, ST_CLEAR} state_t;

  state_t state;
  item_t cur;
  logic [SLOT_W-1:0] idx, n;
  logic [CNT_W-1:0] entry_count;
  logic [6:0] limit;
  logic [6:0] limit_c;
  logic over;
  logic empty_slot, hit, last;
  logic we;
  slot_t wslot, rslot;
  logic [$bits(slot_t)-1:0] rdata;

  skht_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(idx), .wdata(wslot), .raddr(idx), .rdata(rdata)
  );

  assign rslot = slot_t'(rdata);
  assign init_busy = (state == ST_INIT);
  assign pop = (state == ST_IDLE) && !q_status.empty && !out_valid;

  always_comb begin
    limit_c = (limit > LIMIT_CAP) ? LIMIT_CAP : limit;
    over = (LIM_W'(entry_count) + LIM_W'(1)) * LIM_W'(100) >
           LIM_W'(TABLE_SLOTS) * LIM_W'(limit_c);
    empty_slot = (rslot.tag == 4'd0);
    hit = (rslot.tag == cur.tag) && (rslot.key == cur.key);
    last = (n == SLOT_W'(TABLE_SLOTS - 1));
    wslot = '0;
    we = 1'b0;
    if (state == ST_INIT || state == ST_CLEAR) begin
      we = 1'b1;
    end else if (state == ST_CHECK && cur.mode == MODE_UPSERT) begin
      wslot.tag = cur.tag;
      wslot.key = cur.key;
      wslot.value = cur.value;
      we = hit || (empty_slot && !over);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      idx <= '0;
      n <= '0;
      entry_count <= '0;
      limit <= LIMIT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        limit <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          idx <= idx + 1'b1;
          if (idx == SLOT_W'(TABLE_SLOTS - 1)) begin
            idx <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            cur <= head;
            n <= '0;
            if (head.mode == MODE_CLEAR) begin
              idx <= '0;
              state <= ST_CLEAR;
            end else if (head.mode inside {MODE_LOOKUP, MODE_UPSERT}) begin
              idx <= head.home;
              state <= ST_READ;
            end else begin
              out_valid <= 1'b1;
              status <= STATUS_OK;
              found_value <= '0;
            end
          end
        end
        ST_READ: state <= ST_CHECK;
        ST_CHECK: begin
          state <= ST_IDLE;
          found_value <= '0;
          if (empty_slot) begin
            out_valid <= 1'b1;
            if (cur.mode == MODE_LOOKUP) begin
              status <= STATUS_MISS;
            end else if (over) begin
              status <= STATUS_FULL;
            end else begin
              status <= STATUS_OK;
              entry_count <= entry_count + 1'b1;
            end
          end else if (hit) begin
            out_valid <= 1'b1;
            status <= STATUS_OK;
            if (cur.mode == MODE_LOOKUP) begin
              found_value <= rslot.value;
            end
          end else if (last) begin
            out_valid <= 1'b1;
            status <= (cur.mode == MODE_LOOKUP) ? STATUS_MISS : STATUS_FULL;
          end else begin
            n <= n + 1'b1;
            idx <= (idx == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx + 1'b1;
            state <= ST_READ;
          end
        end
        ST_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == SLOT_W'(TABLE_SLOTS - 1)) begin
            idx <= '0;
            entry_count <= '0;
            out_valid <= 1'b1;
            status <= STATUS_OK;
            found_value <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

[hdl/short_key_hash_table.sv]
// A request passes the hash stages, enters the queue and is dequeued by the
// probe engine, which reads and then checks each slot probed. Requests are probed
// one at a time on the single slot RAM read port; a new one is taken only when the
// engine is idle and no result is waiting. Clear sweeps the slot RAM. After
// synchronous reset the same sweep runs with requests stalled.
`timescale 1ns / 1ps
module short_key_hash_table import skht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] key_bytes,
  input  logic [3:0]  key_len,
  input  logic [31:0] new_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] found_value,
  input  logic        cfg_write,
  input  logic [6:0]  cfg_data
);
  q_status_t q_status;
  item_t push_item, head;
  logic push, pop, front_stall, init_busy, in_ok;

  assign in_stall = front_stall || init_busy;
  assign in_ok = in_valid && !init_busy;

  skht_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_ok), .in_stall(front_stall),
    .mode(mode), .key_bytes(key_bytes), .key_len(key_len), .new_value(new_value),
    .q_status(q_status), .push(push), .push_item(push_item)
  );

  skht_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item),
    .pop(pop), .head(head), .q_status(q_status)
  );

  skht_back u_back (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .q_status(q_status), .head(head), .pop(pop), .init_busy(init_busy),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .found_value(found_value)
  );
endmodule

[hdl/skht_checker.sv]
// Port-level checker for short_key_hash_table, bound to the top level.
// Depends on skht_pkg and short_key_hash_table_macros.svh.
`timescale 1ns / 1ps
`include "short_key_hash_table_macros.svh"
module skht_checker import skht_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [31:0] found_value
);
  logic stalled;
  logic [33:0] res;

  assign stalled = out_valid && out_stall;
  assign res = {status, found_value};

  `SKHT_ASSERT_ALWAYS(a_reset_sweep, rst |=> in_stall, "request taken during slot sweep")
  `SKHT_ASSERT(a_status_code, out_valid |-> status <= STATUS_FULL, "bad status code")
  `SKHT_ASSERT(a_value_zero, (out_valid && status != STATUS_OK) |-> found_value == '0, "value on miss")
  `SKHT_ASSERT(a_out_hold, stalled |=> out_valid && $stable(res), "stalled result changed")
endmodule

bind short_key_hash_table skht_checker u_skht_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for short_key_hash_table: random and directed lookup,
// upsert, clear and reserved requests checked against a behavioural table model.
// Depends on skht_pkg and the short_key_hash_table RTL.
`timescale 1ns / 1ps
module testbench;
  import skht_pkg::*;

  localparam int WATCHDOG = 200000;

  class hash_scoreboard;
    logic [3:0]  tags[TABLE_SLOTS];
    logic [63:0] keys[TABLE_SLOTS];
    logic [31:0] vals[TABLE_SLOTS];
    int          entries;
    int          limit_pct;
    logic [1:0]  exp_status[$];
    logic [31:0] exp_value[$];
    int          mismatches;

    function void reset_table();
      foreach (tags[i]) tags[i] = 4'd0;
      entries = 0;
      limit_pct = LIMIT_RESET;
      mismatches = 0;
    endfunction

    function logic [63:0] pack(logic [63:0] w, int len);
      logic [63:0] k;
      int pos;
      k = 0;
      pos = 0;
      if (len >= 8) return w;
      if (len & 4) begin
        k = w & 64'hFFFF_FFFF;
        pos = 4;
      end
      if (len & 2) begin
        k = (k << 16) | w[8*pos +: 8] | (64'(w[8*(pos+1) +: 8]) << 8);
        pos += 2;
      end
      if (len & 1) k = (k << 8) | w[8*pos +: 8];
      return k;
    endfunction

    function logic [31:0] mix(logic [63:0] p, int len);
      logic [63:0] h;
      h = GOLDEN_MUL ^ 64'(len);
      h ^= p;
      h *= GOLDEN_MUL;
      h ^= h >> 29;
      h ^= h >> 32;
      h *= FINAL_MUL;
      h ^= h >> 29;
      return h[31:0] ^ h[63:32];
    endfunction

    function void note_request(logic [1:0] m, logic [63:0] kb, logic [3:0] kl,
                               logic [31:0] nv);
      logic [63:0] p;
      logic [3:0] tag;
      int len, j, n, lim;
      logic [1:0] st;
      logic [31:0] fv;
      st = STATUS_OK;
      fv = 0;
      if (m == MODE_CLEAR) begin
        foreach (tags[i]) tags[i] = 4'd0;
        entries = 0;
      end else if (m == MODE_LOOKUP || m == MODE_UPSERT) begin
        len = (kl > 8) ? 8 : kl;
        p = pack(kb, len);
        tag = 4'(len + 1);
        j = mix(p, len) % TABLE_SLOTS;
        for (n = 0; n < TABLE_SLOTS; n++) begin
          if (tags[j] == 0) break;
          if (tags[j] == tag && keys[j] == p) break;
          j = (j + 1) % TABLE_SLOTS;
        end
        if (n < TABLE_SLOTS && tags[j] != 0) begin
          if (m == MODE_LOOKUP) fv = vals[j];
          else vals[j] = nv;
        end else if (m == MODE_LOOKUP) begin
          st = STATUS_MISS;
        end else begin
          lim = (limit_pct > LIMIT_CAP) ? LIMIT_CAP : limit_pct;
          if (n >= TABLE_SLOTS || (entries + 1) * 100 > TABLE_SLOTS * lim) begin
            st = STATUS_FULL;
          end else begin
            tags[j] = tag;
            keys[j] = p;
            vals[j] = nv;
            entries++;
          end
        end
      end
      exp_status.push_back(st);
      exp_value.push_back(fv);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] fv);
      logic [1:0] es;
      logic [31:0] ev;
      if (exp_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d value=%h", st, fv);
        return;
      end
      es = exp_status.pop_front();
      ev = exp_value.pop_front();
      if (st !== es || fv !== ev) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                   es, st, ev, fv);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0, cfg_write = 0;
  logic [1:0] mode = 0, status;
  logic [63:0] key_bytes = 0;
  logic [3:0] key_len = 0;
  logic [31:0] new_value = 0, found_value;
  logic [6:0] cfg_data = 0;
  hash_scoreboard sb;
  int idle_cycles = 0;
  logic [63:0] key_pool[32];
  logic [3:0] len_pool[32];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  short_key_hash_table uut (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(status, found_value);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("testbench: FAIL");
        $finish;
      end
      case ($urandom_range(0, 3))
        0: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= out_stall & ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  task automatic send(logic [1:0] m, logic [63:0] kb, logic [3:0] kl, logic [31:0] nv);
    in_valid <= 1;
    mode <= m;
    key_bytes <= kb;
    key_len <= kl;
    new_value <= nv;
    do @(posedge clk); while (in_stall);
    sb.note_request(m, kb, kl, nv);
  endtask

  task automatic pause(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    pause(0);
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(logic [6:0] v);
    drain();
    cfg_write <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
    sb.limit_pct = v;
  endtask

  function automatic logic [63:0] masked(logic [63:0] w, int len);
    return (len >= 8) ? w : (w & ((64'd1 << (8 * len)) - 1));
  endfunction

  task automatic random_item(int pool_bias);
    int p, len;
    logic [63:0] kb;
    logic [1:0] m;
    p = $urandom_range(0, 31);
    m = 2'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < pool_bias) begin
      kb = key_pool[p];
      len = len_pool[p];
    end else begin
      len = $urandom_range(0, 15);
      kb = masked({$urandom, $urandom}, len);
    end
    if ($urandom_range(0, 199) == 0) m = MODE_CLEAR;
    else if ($urandom_range(0, 99) == 0) m = MODE_RESERVED;
    send(m, kb, 4'(len), $urandom);
    if ($urandom_range(0, 5) == 0) pause($urandom_range(1, 6));
  endtask

  initial begin
    int burst;
    int lims[5];
    lims = '{1, 127, 99, 5, 70};
    sb = new();
    sb.reset_table();
    foreach (key_pool[i]) begin
      len_pool[i] = 4'($urandom_range(0, 8));
      key_pool[i] = masked({$urandom, $urandom}, len_pool[i]);
    end
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send(MODE_LOOKUP, 0, 0, 0);
    send(MODE_UPSERT, 0, 0, 32'hFFFF_FFFF);
    send(MODE_LOOKUP, 0, 0, 0);
    send(MODE_UPSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8, 32'h1234_5678);
    send(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 15, 0);
    send(MODE_UPSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8, 0);
    send(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8, 0);
    for (int l = 1; l <= 7; l++) begin
      send(MODE_UPSERT, 64'hA5A5_5A5A_0102_0304, 4'(l), 32'(l));
      send(MODE_LOOKUP, 64'hA5A5_5A5A_0102_0304, 4'(l), 0);
    end
    send(MODE_LOOKUP, 64'h00, 1, 0);
    send(MODE_RESERVED, 64'h1, 1, 32'h5);
    send(MODE_CLEAR, 0, 0, 0);
    send(MODE_LOOKUP, 0, 0, 0);
    // limit zero: after the clear every upsert is a new key and is refused
    set_limit(0);
    send(MODE_UPSERT, 64'h11, 1, 7);
    send(MODE_UPSERT, 0, 0, 9);
    send(MODE_UPSERT, 0, 0, 3);
    send(MODE_LOOKUP, 0, 0, 0);
    // random phases across limits, bursty sender
    foreach (lims[ph]) begin
      set_limit(7'(lims[ph]));
      for (int i = 0; i < 200; i += burst) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst; b++) random_item(70);
        pause($urandom_range(1, 8));
      end
      if (ph == 1) begin
        // fill towards the limit with fresh keys
        for (int i = 0; i < 60; i++) send(MODE_UPSERT, {$urandom, $urandom}, 8, $urandom);
        send(MODE_CLEAR, 0, 0, 0);
      end
    end
    drain();
    if (sb.mismatches == 0 && sb.exp_status.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
